[rtl/core/tmr_pkg.sv]
package tmr_pkg;

  // item and result field widths
  localparam int OP_W       = 3;
  localparam int ADDR_W     = 13;
  localparam int DATA_W     = 8;
  localparam int PIX_X_W    = 8;
  localparam int PIX_Y_W    = 9;
  localparam int COLOR_W    = 8;
  localparam int ROW_W      = PIX_Y_W - 3;
  localparam int SX_W       = PIX_X_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TBANK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PBANK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CBANK  = 3'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_VRAM   = 3'd0;
  localparam logic [OP_W-1:0] OP_TILE   = 3'd1;
  localparam logic [OP_W-1:0] OP_PAL    = 3'd2;
  localparam logic [OP_W-1:0] OP_COLOR  = 3'd3;
  localparam logic [OP_W-1:0] OP_RENDER = 3'd4;

  // memory sizes
  localparam int VRAM_DEPTH     = 4096;
  localparam int TROM_DEPTH     = 8192;
  localparam int PROM_DEPTH     = 1024;
  localparam int CPROM_DEPTH    = 256;
  localparam int VRAM_AW        = $clog2(VRAM_DEPTH);
  localparam int TROM_AW        = $clog2(TROM_DEPTH);
  localparam int PROM_AW        = $clog2(PROM_DEPTH);
  localparam int CPROM_AW       = $clog2(CPROM_DEPTH);

  // tile map geometry
  localparam int TILE_ROWS      = 36;
  localparam int PAL_RAM_OFFSET = 1024;
  localparam int SCROLL_WRAP    = 8 * 54;
  localparam int ROW_SHIFT      = 5;
  localparam int ROW_STEP       = 32;
  localparam int CLS_TOP_BASE   = 'h3C2;
  localparam int CLS_BOT_BASE   = 'h02;
  localparam int CLS_MID_BASE   = 'h40;
  localparam int VAR_TILE_BASE  = 1858;
  localparam int VAR_PAL_BASE   = 1986;

  // resistor weights
  localparam logic [COLOR_W-1:0] W_RG0 = 8'h21;
  localparam logic [COLOR_W-1:0] W_RG1 = 8'h47;
  localparam logic [COLOR_W-1:0] W_RG2 = 8'h97;
  localparam logic [COLOR_W-1:0] W_B0  = 8'h51;
  localparam logic [COLOR_W-1:0] W_B1  = 8'hAE;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  function automatic logic [COLOR_W-1:0] rg_level(input logic [2:0] bits);
    rg_level = (bits[0] ? W_RG0 : '0) + (bits[1] ? W_RG1 : '0) + (bits[2] ? W_RG2 : '0);
  endfunction

  function automatic logic [COLOR_W-1:0] b_level(input logic [1:0] bits);
    b_level = (bits[0] ? W_B0 : '0) + (bits[1] ? W_B1 : '0);
  endfunction

endpackage

[rtl/core/tmr_ifs.sv]
interface tmr_in_if import tmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ADDR_W-1:0]  addr;
  logic [DATA_W-1:0]  data;
  logic [PIX_X_W-1:0] pix_x;
  logic [PIX_Y_W-1:0] pix_y;

  modport source (output valid, op, addr, data, pix_x, pix_y, input ready);
  modport sink   (input valid, op, addr, data, pix_x, pix_y, output ready);
endinterface

interface tmr_out_if import tmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               bg_prio;

  modport source (output valid, red, green, blue, bg_prio, input ready);
  modport sink   (input valid, red, green, blue, bg_prio, output ready);
endinterface

interface tmr_cfg_if import tmr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

[rtl/core/tilemap_pixel_renderer_core.sv]
// A render passes the video RAM, tile ROM, palette ROM and color PROM reads and the resistor
// weighting, and is written into the result queue before it turns valid on out_ch.
// Throughput: one item per cycle when in_ch.ready is high; each memory is read at its own stage.
// Writes land in the memory at the stage where renders read it, so all accesses stay in order.
// A render may enter while fewer than 8 results are outstanding (queue of 8).
// Reset clears the pipeline valid bits, the result queue and the configuration registers.
// Memory contents are undefined until written; there is no clearing pass.
module tilemap_pixel_renderer_core import tmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tmr_in_if.sink     in_ch,
  tmr_out_if.source  out_ch,
  tmr_cfg_if.sink    cfg_ch
);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_t;

  typedef struct packed {
    wr_t        wr;
    logic [2:0] sx_lo;
    logic [2:0] px;
  } s1_t;

  typedef struct packed {
    wr_t        wr;
    logic [1:0] px_lo;
    logic [7:0] pidx;
  } s2_t;

  typedef struct packed {
    wr_t        wr;
    logic [1:0] pc;
  } s3_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               bg_prio;
  } pix_t;

  // configuration
  logic       layout_r;
  logic [7:0] scroll_r;
  logic       tbank_r;
  logic [2:0] pbank_r;
  logic [3:0] cbank_r;

  // pipeline
  logic v1_r, v2_r, v3_r, v4_r;
  s1_t  s1_r;
  s2_t  s2_r;
  s3_t  s3_r;
  logic [1:0] pc4_r;

  // result queue
  pix_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, rptr_r;
  logic [FIFO_CW-1:0] cnt_r, resv_r;

  logic in_acc, out_acc, push;

  // stage 0 signals
  logic [ROW_W-1:0]   row;
  logic               mid;
  logic [SX_W-1:0]    scr_sum, scr_wrap, sx;
  logic [5:0]         col;
  logic [VRAM_AW-1:0] col_w, row_w, cls_a, var_t, var_p, vt_addr, vp_addr;
  logic [DATA_W-1:0]  vt_rdata, vp_rdata;

  // later stage signals
  logic [TROM_AW-1:0]  trom_raddr;
  logic [DATA_W-1:0]   trom_rdata;
  logic [1:0]          pc2;
  logic [PROM_AW-1:0]  prom_raddr;
  logic [DATA_W-1:0]   prom_rdata;
  logic [CPROM_AW-1:0] cprom_raddr;
  logic [DATA_W-1:0]   cprom_rdata;
  pix_t                pix4;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_acc      = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = resv_r < FIFO_CW'(FIFO_DEPTH);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= 1'b0;
      scroll_r <= '0;
      tbank_r  <= 1'b0;
      pbank_r  <= '0;
      cbank_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.idx)
        CFG_LAYOUT: layout_r <= cfg_ch.wdata[0];
        CFG_SCROLL: scroll_r <= cfg_ch.wdata;
        CFG_TBANK:  tbank_r  <= cfg_ch.wdata[0];
        CFG_PBANK:  pbank_r  <= cfg_ch.wdata[2:0];
        CFG_CBANK:  cbank_r  <= cfg_ch.wdata[3:0];
        default: ;
      endcase
    end
  end

  // stage 0: scroll and video RAM addressing
  always_comb begin
    row      = in_ch.pix_y[PIX_Y_W-1:3];
    mid      = (row >= ROW_W'(2)) && (row < ROW_W'(TILE_ROWS - 2));
    scr_sum  = {1'b0, in_ch.pix_x} + {1'b0, scroll_r};
    scr_wrap = (scr_sum >= SX_W'(SCROLL_WRAP)) ? scr_sum - SX_W'(SCROLL_WRAP) : scr_sum;
    sx       = mid ? scr_wrap : {1'b0, in_ch.pix_x};
    col      = sx[SX_W-1:3];
    col_w    = VRAM_AW'(col);
    row_w    = VRAM_AW'(row);

    if (row < ROW_W'(2)) begin
      cls_a = VRAM_AW'(CLS_TOP_BASE) + col_w + (row_w << ROW_SHIFT);
    end else if (row >= ROW_W'(TILE_ROWS - 2)) begin
      cls_a = VRAM_AW'(CLS_BOT_BASE) + col_w
            + ((row_w - VRAM_AW'(TILE_ROWS - 2)) << ROW_SHIFT);
    end else begin
      cls_a = VRAM_AW'(CLS_MID_BASE) + (row_w - VRAM_AW'(2)) + (col_w << ROW_SHIFT);
    end

    if (row == ROW_W'(0)) begin
      var_t = VRAM_AW'(VAR_TILE_BASE) + col_w;
      var_p = VRAM_AW'(VAR_PAL_BASE) + col_w;
    end else if (row == ROW_W'(1)) begin
      var_t = VRAM_AW'(VAR_TILE_BASE + ROW_STEP) + col_w;
      var_p = VRAM_AW'(VAR_PAL_BASE + ROW_STEP) + col_w;
    end else if (row == ROW_W'(TILE_ROWS - 2)) begin
      var_t = VRAM_AW'(VAR_TILE_BASE - 2 * ROW_STEP) + col_w;
      var_p = VRAM_AW'(VAR_PAL_BASE - 2 * ROW_STEP) + col_w;
    end else if (row == ROW_W'(TILE_ROWS - 1)) begin
      var_t = VRAM_AW'(VAR_TILE_BASE - ROW_STEP) + col_w;
      var_p = VRAM_AW'(VAR_PAL_BASE - ROW_STEP) + col_w;
    end else begin
      var_t = VRAM_AW'(CLS_MID_BASE) + (row_w - VRAM_AW'(2)) + (col_w << ROW_SHIFT);
      var_p = row_w - VRAM_AW'(2);
    end

    vt_addr = layout_r ? var_t : cls_a;
    vp_addr = layout_r ? var_p : cls_a + VRAM_AW'(PAL_RAM_OFFSET);
  end

  // two copies of video RAM give the tile and palette bytes in the same cycle
  tmr_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_DEPTH)) u_vram_tile (
    .clk   (clk),
    .we    (in_acc && in_ch.op == OP_VRAM),
    .waddr (in_ch.addr[VRAM_AW-1:0]),
    .wdata (in_ch.data),
    .raddr (vt_addr),
    .rdata (vt_rdata)
  );

  tmr_ram #(.WIDTH(DATA_W), .DEPTH(VRAM_DEPTH)) u_vram_pal (
    .clk   (clk),
    .we    (in_acc && in_ch.op == OP_VRAM),
    .waddr (in_ch.addr[VRAM_AW-1:0]),
    .wdata (in_ch.data),
    .raddr (vp_addr),
    .rdata (vp_rdata)
  );

  // stage 1: rotated in-tile coordinate picks the tile ROM byte
  assign trom_raddr = TROM_AW'({tbank_r, vt_rdata, ~s1_r.px[2], s1_r.sx_lo});

  tmr_ram #(.WIDTH(DATA_W), .DEPTH(TROM_DEPTH)) u_tile_rom (
    .clk   (clk),
    .we    (v1_r && s1_r.wr.op == OP_TILE),
    .waddr (s1_r.wr.addr[TROM_AW-1:0]),
    .wdata (s1_r.wr.data),
    .raddr (trom_raddr),
    .rdata (trom_rdata)
  );

  // stage 2: pixel code and palette ROM lookup
  assign pc2        = {trom_rdata[{1'b1, ~s2_r.px_lo}], trom_rdata[{1'b0, ~s2_r.px_lo}]};
  assign prom_raddr = PROM_AW'({s2_r.pidx, pc2});

  tmr_ram #(.WIDTH(DATA_W), .DEPTH(PROM_DEPTH)) u_pal_rom (
    .clk   (clk),
    .we    (v2_r && s2_r.wr.op == OP_PAL),
    .waddr (s2_r.wr.addr[PROM_AW-1:0]),
    .wdata (s2_r.wr.data),
    .raddr (prom_raddr),
    .rdata (prom_rdata)
  );

  // stage 3: color PROM lookup with bank bits over the upper nibble
  assign cprom_raddr = CPROM_AW'({prom_rdata[7:4] | cbank_r, prom_rdata[3:0]});

  tmr_ram #(.WIDTH(DATA_W), .DEPTH(CPROM_DEPTH)) u_color_prom (
    .clk   (clk),
    .we    (v3_r && s3_r.wr.op == OP_COLOR),
    .waddr (s3_r.wr.addr[CPROM_AW-1:0]),
    .wdata (s3_r.wr.data),
    .raddr (cprom_raddr),
    .rdata (cprom_rdata)
  );

  // stage 4: resistor weighting
  always_comb begin
    pix4.red     = rg_level(cprom_rdata[2:0]);
    pix4.green   = rg_level(cprom_rdata[5:3]);
    pix4.blue    = b_level(cprom_rdata[7:6]);
    pix4.bg_prio = |pc4_r;
  end

  assign push = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
      resv_r <= '0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && s3_r.wr.op == OP_RENDER;
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (out_acc) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r  <= cnt_r + FIFO_CW'(push) - FIFO_CW'(out_acc);
      resv_r <= resv_r + FIFO_CW'(in_acc && in_ch.op == OP_RENDER) - FIFO_CW'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    s1_r.wr.op   <= in_ch.op;
    s1_r.wr.addr <= in_ch.addr;
    s1_r.wr.data <= in_ch.data;
    s1_r.sx_lo   <= sx[2:0];
    s1_r.px      <= in_ch.pix_y[2:0];
    s2_r.wr      <= s1_r.wr;
    s2_r.px_lo   <= s1_r.px[1:0];
    s2_r.pidx    <= {pbank_r, vp_rdata[4:0]};
    s3_r.wr      <= s2_r.wr;
    s3_r.pc      <= pc2;
    pc4_r        <= s3_r.pc;
    if (push) begin
      fifo_r[wptr_r] <= pix4;
    end
  end

  assign out_ch.valid   = cnt_r != '0;
  assign out_ch.red     = fifo_r[rptr_r].red;
  assign out_ch.green   = fifo_r[rptr_r].green;
  assign out_ch.blue    = fifo_r[rptr_r].blue;
  assign out_ch.bg_prio = fifo_r[rptr_r].bg_prio;

endmodule

[rtl/core/tmr_ram.sv]
module tmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/tmr_checker.sv]
module tmr_checker import tmr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_W-1:0]    in_op,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] out_red,
  input logic [COLOR_W-1:0] out_green,
  input logic [COLOR_W-1:0] out_blue,
  input logic               out_bg
);

  logic [FIFO_CW:0] pend_r;

  // count renders taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + (FIFO_CW + 1)'(in_valid && in_ready && in_op == OP_RENDER)
              - (FIFO_CW + 1)'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_bg))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result with no outstanding render");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= (FIFO_CW + 1)'(FIFO_DEPTH))
    else $error("more renders outstanding than the queue holds");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind tilemap_pixel_renderer_core tmr_checker u_tmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red),
  .out_green (out_ch.green),
  .out_blue  (out_ch.blue),
  .out_bg    (out_ch.bg_prio)
);

[sim/tilemap_pixel_renderer_core_tb.sv]
`timescale 1ns / 1ps

module tilemap_pixel_renderer_core_tb;
  import tmr_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [PIX_X_W-1:0] pix_x;
    logic [PIX_Y_W-1:0] pix_y;
  } video_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               bg_prio;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  tmr_in_if  in_ch ();
  tmr_out_if out_ch ();
  tmr_cfg_if cfg_ch ();

  tilemap_pixel_renderer_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // local copy of the memories, with a flag per entry once it holds data
  logic [7:0] vram_mem  [VRAM_DEPTH];
  logic [7:0] trom_mem  [TROM_DEPTH];
  logic [7:0] prom_mem  [PROM_DEPTH];
  logic [7:0] cprom_mem [CPROM_DEPTH];
  bit         vram_set  [VRAM_DEPTH];
  bit         trom_set  [TROM_DEPTH];
  bit         prom_set  [PROM_DEPTH];
  bit         cprom_set [CPROM_DEPTH];

  int layout_r, scroll_r, tbank_r, pbank_r, cbank_r;

  video_item_t video_items[$];
  pixel_t      expected_pixels[$];
  int          items_made;
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  int          stuck_cycles;

  task automatic push_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data, input logic [PIX_X_W-1:0] x,
                           input logic [PIX_Y_W-1:0] y);
    video_item_t it;
    it = '{op: op, addr: addr, data: data, pix_x: x, pix_y: y};
    video_items.push_back(it);
    case (op)
      OP_VRAM: begin
        vram_mem[addr % VRAM_DEPTH] = data;
        vram_set[addr % VRAM_DEPTH] = 1'b1;
      end
      OP_TILE: begin
        trom_mem[addr % TROM_DEPTH] = data;
        trom_set[addr % TROM_DEPTH] = 1'b1;
      end
      OP_PAL: begin
        prom_mem[addr % PROM_DEPTH] = data;
        prom_set[addr % PROM_DEPTH] = 1'b1;
      end
      OP_COLOR: begin
        cprom_mem[addr % CPROM_DEPTH] = data;
        cprom_set[addr % CPROM_DEPTH] = 1'b1;
      end
      default: ;
    endcase
    if (op <= OP_RENDER) items_made++;
  endtask

  // load a random byte into an entry a render is about to read, if it holds none yet
  task automatic fill_if_blank(input logic [OP_W-1:0] op, input int a);
    bit present;
    int depth;
    case (op)
      OP_VRAM:  begin present = vram_set[a];  depth = VRAM_DEPTH;  end
      OP_TILE:  begin present = trom_set[a];  depth = TROM_DEPTH;  end
      OP_PAL:   begin present = prom_set[a];  depth = PROM_DEPTH;  end
      default:  begin present = cprom_set[a]; depth = CPROM_DEPTH; end
    endcase
    if (!present)
      push_item(op, a + depth * $urandom_range(TROM_DEPTH / depth - 1), $urandom,
                $urandom, $urandom);
  endtask

  function automatic void map_tile_cell(input int col, input int row, output int ta,
                                        output int pa);
    int base;
    if (layout_r == 0) begin
      if (row < 2)
        base = CLS_TOP_BASE + col + row * ROW_STEP;
      else if (row >= TILE_ROWS - 2)
        base = CLS_BOT_BASE + col + (row - (TILE_ROWS - 2)) * ROW_STEP;
      else
        base = CLS_MID_BASE + (row - 2) + col * ROW_STEP;
      ta = base % VRAM_DEPTH;
      pa = (base + PAL_RAM_OFFSET) % VRAM_DEPTH;
    end else begin
      // rows past the bottom fall into the middle-row case here
      if (row == 0) begin
        ta = VAR_TILE_BASE + col;
        pa = VAR_PAL_BASE + col;
      end else if (row == 1) begin
        ta = VAR_TILE_BASE + ROW_STEP + col;
        pa = VAR_PAL_BASE + ROW_STEP + col;
      end else if (row == TILE_ROWS - 2) begin
        ta = VAR_TILE_BASE - 2 * ROW_STEP + col;
        pa = VAR_PAL_BASE - 2 * ROW_STEP + col;
      end else if (row == TILE_ROWS - 1) begin
        ta = VAR_TILE_BASE - ROW_STEP + col;
        pa = VAR_PAL_BASE - ROW_STEP + col;
      end else begin
        ta = CLS_MID_BASE + (row - 2) + col * ROW_STEP;
        pa = row - 2;
      end
      ta = ta % VRAM_DEPTH;
      pa = pa % VRAM_DEPTH;
    end
  endfunction

  task automatic predict_pixel(input logic [PIX_X_W-1:0] x, input logic [PIX_Y_W-1:0] y);
    int row, sx, col, ta, pa, tsel, trom_a, pidx, prom_a, cidx;
    logic [7:0] tbyte, cval;
    logic [1:0] code;
    pixel_t px;
    row = y >> 3;
    sx = x;
    if (row >= 2 && row < TILE_ROWS - 2) sx = (x + scroll_r) % SCROLL_WRAP;
    col = sx >> 3;
    map_tile_cell(col, row, ta, pa);
    fill_if_blank(OP_VRAM, ta);
    fill_if_blank(OP_VRAM, pa);
    // rotated tile: the screen column picks the byte, the line picks the bit
    tsel = (y[2:0] >= 4) ? (sx & 7) : 8 + (sx & 7);
    trom_a = ((tbank_r != 0 ? TROM_DEPTH / 2 : 0) + int'(vram_mem[ta]) * 16 + tsel)
             % TROM_DEPTH;
    fill_if_blank(OP_TILE, trom_a);
    tbyte = trom_mem[trom_a];
    code = {tbyte[7 - y[1:0]], tbyte[3 - y[1:0]]};
    pidx = ((int'(vram_mem[pa]) & 31) | (pbank_r << 5)) & 255;
    prom_a = (pidx * 4 + int'(code)) % PROM_DEPTH;
    fill_if_blank(OP_PAL, prom_a);
    cidx = (int'(prom_mem[prom_a]) | (cbank_r << 4)) & 255;
    fill_if_blank(OP_COLOR, cidx);
    cval = cprom_mem[cidx];
    px.red   = (cval[0] ? W_RG0 : 8'd0) + (cval[1] ? W_RG1 : 8'd0) + (cval[2] ? W_RG2 : 8'd0);
    px.green = (cval[3] ? W_RG0 : 8'd0) + (cval[4] ? W_RG1 : 8'd0) + (cval[5] ? W_RG2 : 8'd0);
    px.blue  = (cval[6] ? W_B0 : 8'd0) + (cval[7] ? W_B1 : 8'd0);
    px.bg_prio = (code != 2'd0);
    push_item(OP_RENDER, $urandom, $urandom, x, y);
    expected_pixels.push_back(px);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.wdata <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_LAYOUT: layout_r = val & 1;
      CFG_SCROLL: scroll_r = val & 255;
      CFG_TBANK:  tbank_r  = val & 1;
      CFG_PBANK:  pbank_r  = val & 7;
      CFG_CBANK:  cbank_r  = val & 15;
      default: ;
    endcase
  endtask

  // hold until every item is in and every pixel is out, then let the pipeline settle
  task automatic wait_drained(input int settle);
    do @(negedge clk);
    while (video_items.size() != 0 || in_ch.valid || expected_pixels.size() != 0);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    video_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (video_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = video_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op    <= nxt.op;
        in_ch.addr  <= nxt.addr;
        in_ch.data  <= nxt.data;
        in_ch.pix_x <= nxt.pix_x;
        in_ch.pix_y <= nxt.pix_y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected pixel: r=%h g=%h b=%h pri=%b", out_ch.red, out_ch.green,
                     out_ch.blue, out_ch.bg_prio);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.red !== want.red || out_ch.green !== want.green ||
              out_ch.blue !== want.blue || out_ch.bg_prio !== want.bg_prio) begin
            if (mismatches < 10)
              $display("pixel mismatch: expected r=%h g=%h b=%h pri=%b, got r=%h g=%h b=%h pri=%b",
                       want.red, want.green, want.blue, want.bg_prio, out_ch.red,
                       out_ch.green, out_ch.blue, out_ch.bg_prio);
            mismatches++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tilemap_pixel_renderer_core_tb NOT OK");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int phase_goal;
    int pick;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_VRAM;
    in_ch.addr   = '0;
    in_ch.data   = '0;
    in_ch.pix_x  = '0;
    in_ch.pix_y  = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.idx   = CFG_LAYOUT;
    cfg_ch.wdata = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    stuck_cycles = 0;
    mismatches   = 0;
    items_made   = 0;
    layout_r = 0;
    scroll_r = 0;
    tbank_r  = 0;
    pbank_r  = 0;
    cbank_r  = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: address and data extremes for each store, unused codes, screen corners
    push_item(OP_VRAM, '0, 8'h00, $urandom, $urandom);
    push_item(OP_VRAM, '1, 8'hFF, $urandom, $urandom);
    push_item(OP_TILE, '0, 8'hFF, $urandom, $urandom);
    push_item(OP_TILE, '1, 8'h00, $urandom, $urandom);
    push_item(OP_PAL, '0, 8'h00, $urandom, $urandom);
    push_item(OP_PAL, '1, 8'hFF, $urandom, $urandom);
    push_item(OP_COLOR, '0, 8'hFF, $urandom, $urandom);
    push_item(OP_COLOR, '1, 8'h00, $urandom, $urandom);
    for (int o = OP_RENDER + 1; o < (1 << OP_W); o++)
      push_item(o, $urandom, $urandom, $urandom, $urandom);
    predict_pixel(8'd0, 9'd0);
    predict_pixel(8'd223, 9'd287);
    predict_pixel(8'd255, 9'd511);
    predict_pixel(8'd0, 9'd8);
    predict_pixel(8'd100, 9'd16);
    predict_pixel(8'd255, 9'd100);
    predict_pixel(8'd255, 9'd272);
    predict_pixel(8'd7, 9'd287);
    predict_pixel(8'd31, 9'd290);
    wait_drained(12);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        write_cfg(CFG_LAYOUT, 1);
        write_cfg(CFG_SCROLL, 255);
        write_cfg(CFG_TBANK, 1);
        write_cfg(CFG_PBANK, 7);
        write_cfg(CFG_CBANK, 15);
      end else if (ph == 1) begin
        write_cfg(CFG_LAYOUT, 0);
        write_cfg(CFG_SCROLL, 0);
        write_cfg(CFG_TBANK, 0);
        write_cfg(CFG_PBANK, 0);
        write_cfg(CFG_CBANK, 0);
      end else begin
        write_cfg(CFG_LAYOUT, ph & 1);
        write_cfg(CFG_SCROLL, $urandom_range(255));
        write_cfg(CFG_TBANK, $urandom_range(1));
        write_cfg(CFG_PBANK, $urandom_range(7));
        write_cfg(CFG_CBANK, $urandom_range(15));
      end
      @(negedge clk);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      phase_goal = items_made + PHASE_ITEMS;
      while (items_made < phase_goal) begin
        pick = $urandom_range(99);
        if (pick < 4)
          push_item($urandom_range((1 << OP_W) - 1, OP_RENDER + 1), $urandom, $urandom,
                    $urandom, $urandom);
        else if (pick < 30)
          push_item($urandom_range(OP_COLOR, OP_VRAM), $urandom, $urandom, $urandom, $urandom);
        else
          predict_pixel(($urandom_range(99) < 85) ? $urandom_range(223) : $urandom_range(255),
                        ($urandom_range(99) < 85) ? $urandom_range(287) : $urandom_range(511));
      end
      wait_drained(12);
    end

    wait_drained(20);
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("tilemap_pixel_renderer_core_tb OK");
    else
      $display("tilemap_pixel_renderer_core_tb NOT OK");
    $finish;
  end

endmodule
